>>> rtl/efp_pkg.sv
// Shared constants and types of the escape-time fractal pixel unit.
package efp_pkg;

	localparam int COLORS_DEF  = 256;
	localparam int MAX_DIM_DEF = 4096;

	localparam int COORD_W     = 12;
	localparam int FIX_W       = 32;
	localparam int PROD_W      = 2 * FIX_W;
	localparam int STEP_W      = 31;
	localparam int LIMIT_W     = 16;
	localparam int COLOUR_W    = 8;
	localparam int FRAC_BITS   = 28;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [PROD_W-1:0] ESCAPE_SQ = PROD_W'(4) << (2 * FRAC_BITS);

	localparam logic signed [FIX_W-1:0] ORIGIN_RE_RST = -32'sd536870912;
	localparam logic signed [FIX_W-1:0] ORIGIN_IM_RST = -32'sd268435456;
	localparam logic [STEP_W-1:0]       STEP_RST      = 31'd262144;
	localparam logic [LIMIT_W-1:0]      LIMIT_RST     = 16'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KIND      = 3'd0,
		REG_ORIGIN_RE = 3'd1,
		REG_ORIGIN_IM = 3'd2,
		REG_STEP      = 3'd3,
		REG_LIMIT     = 3'd4,
		REG_JULIA_RE  = 3'd5,
		REG_JULIA_IM  = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		KIND_MANDELBROT = 1'b0,
		KIND_JULIA      = 1'b1
	} fractal_kind_t;

endpackage

>>> rtl/efp_if.sv
// Channel interfaces: pixel input, colour result and register write port.
interface efp_pixel_if import efp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_row;
	logic [COORD_W-1:0] pixel_col;

	modport source (output valid, output pixel_row, output pixel_col, input ready);
	modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

interface efp_result_if import efp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [COORD_W-1:0]  out_row;
	logic [COORD_W-1:0]  out_col;
	logic [COLOUR_W-1:0] colour_index;

	modport source (output valid, output out_row, output out_col, output colour_index,
		input ready);
	modport sink   (input valid, input out_row, input out_col, input colour_index,
		output ready);
endinterface

interface efp_cfg_if import efp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/efp_mul.sv
// Shared signed 32x32 multiplier with registered product.
module efp_mul import efp_pkg::*; (
	input  logic                     clk,
	input  logic signed [FIX_W-1:0]  a,
	input  logic signed [FIX_W-1:0]  b,
	output logic signed [PROD_W-1:0] prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

endmodule

>>> rtl/escape_time_fractal_pixel_unit.sv
// Top level of the escape-time fractal pixel unit (Mandelbrot / Julia).
//
// Usage: write the seven registers on cfg (index 0..6) while the unit is idle;
// cfg.ready is always high and unknown indexes are dropped. Each beat on pixel
// names one pixel; each beat on result echoes row and column with the escape
// count modulo COLORS. One pixel is in work at a time; pixel.ready is high only
// in the idle state.
// Sequence: the point is formed in states PT_RE, PT_IM and PT_END, then every
// iteration runs SQ_RR, SQ_II, SQ_RI and STEP on the one shared 32x32
// multiplier (zr*zr, zi*zi, zr*zi, then the update); a pixel outside MAX_DIM
// goes straight to FINISH.
// A finished result sits in an output register, so the next pixel is taken
// while result is stalled; the unit waits only when a second result is done
// before the first has been taken.
// Reset (arst_n low) returns to idle, empties the output register and loads
// the register defaults: Mandelbrot, origin (-2, -1), step 2^-10, limit 255.
module escape_time_fractal_pixel_unit import efp_pkg::*; #(
	parameter int COLORS  = COLORS_DEF,
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	efp_cfg_if.sink       cfg,
	efp_pixel_if.sink     pixel,
	efp_result_if.source  result
);

	localparam int CW = (COLORS > 2) ? $clog2(COLORS) : 1;
	localparam logic [CW-1:0] COLOR_LAST = CW'(COLORS - 1);
	localparam logic [16:0] MAX_DIM_V = 17'(MAX_DIM);
	localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(64'sd2147483647);
	localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(64'sd2147483648);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PT_RE,
		ST_PT_IM,
		ST_PT_END,
		ST_SQ_RR,
		ST_SQ_II,
		ST_SQ_RI,
		ST_STEP,
		ST_FINISH
	} state_t;

	function automatic logic signed [FIX_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [FIX_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[FIX_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[FIX_W-1:0];
		end else begin
			r = v[FIX_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [PROD_W-1:0] sx(input logic signed [FIX_W-1:0] v);
		return {{(PROD_W-FIX_W){v[FIX_W-1]}}, v};
	endfunction

	fractal_kind_t            kind_q;
	logic signed [FIX_W-1:0]  origin_re_q;
	logic signed [FIX_W-1:0]  origin_im_q;
	logic [STEP_W-1:0]        step_q;
	logic [LIMIT_W-1:0]       limit_q;
	logic signed [FIX_W-1:0]  julia_re_q;
	logic signed [FIX_W-1:0]  julia_im_q;

	state_t                   state_q;
	logic [COORD_W-1:0]       row_q;
	logic [COORD_W-1:0]       col_q;
	logic signed [FIX_W-1:0]  pr_q;
	logic signed [FIX_W-1:0]  zr_q;
	logic signed [FIX_W-1:0]  zi_q;
	logic signed [FIX_W-1:0]  cr_q;
	logic signed [FIX_W-1:0]  ci_q;
	logic signed [PROD_W-1:0] rr_q;
	logic signed [PROD_W-1:0] ii_q;
	logic [LIMIT_W-1:0]       steps_q;
	logic [CW-1:0]            color_q;
	logic                     res_valid_q;
	logic [COORD_W-1:0]       res_row_q;
	logic [COORD_W-1:0]       res_col_q;
	logic [COLOUR_W-1:0]      res_colour_q;

	logic signed [FIX_W-1:0]  mul_a;
	logic signed [FIX_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [FIX_W-1:0]  pt_w;
	logic [PROD_W-1:0]        mag_w;
	logic                     stop_w;
	logic signed [PROD_W-1:0] nr_w;
	logic signed [PROD_W-1:0] ni_w;
	logic [CW+COLOUR_W-1:0]   colour_ext;
	logic                     in_range;
	logic                     pix_fire;
	logic                     out_free;

	// register write port
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= KIND_MANDELBROT;
			origin_re_q <= ORIGIN_RE_RST;
			origin_im_q <= ORIGIN_IM_RST;
			step_q      <= STEP_RST;
			limit_q     <= LIMIT_RST;
			julia_re_q  <= '0;
			julia_im_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_KIND:      kind_q      <= fractal_kind_t'(cfg.data[0]);
				REG_ORIGIN_RE: origin_re_q <= cfg.data;
				REG_ORIGIN_IM: origin_im_q <= cfg.data;
				REG_STEP:      step_q      <= cfg.data[STEP_W-1:0];
				REG_LIMIT:     limit_q     <= cfg.data[LIMIT_W-1:0];
				REG_JULIA_RE:  julia_re_q  <= cfg.data;
				REG_JULIA_IM:  julia_im_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_PT_RE: begin
				mul_a = {{(FIX_W-COORD_W){1'b0}}, col_q};
				mul_b = {1'b0, step_q};
			end
			ST_PT_IM: begin
				mul_a = {{(FIX_W-COORD_W){1'b0}}, row_q};
				mul_b = {1'b0, step_q};
			end
			ST_SQ_RR: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			ST_SQ_II: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
		endcase
	end

	efp_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1)
	);

	assign pt_w   = sat32(prod_s1 + sx((state_q == ST_PT_IM) ? origin_re_q : origin_im_q));
	assign mag_w  = $unsigned(rr_q) + $unsigned(ii_q);
	assign stop_w = (mag_w >= ESCAPE_SQ) || (steps_q >= limit_q);
	assign nr_w   = (rr_q >>> FRAC_BITS) - (ii_q >>> FRAC_BITS) + sx(cr_q);
	assign ni_w   = (prod_s1 >>> (FRAC_BITS - 1)) + sx(ci_q);

	assign in_range   = ({5'b0, pixel.pixel_row} < MAX_DIM_V) &&
		({5'b0, pixel.pixel_col} < MAX_DIM_V);
	assign pix_fire   = pixel.valid && pixel.ready;
	assign out_free   = !res_valid_q || result.ready;
	assign colour_ext = {{COLOUR_W{1'b0}}, color_q};

	assign pixel.ready         = (state_q == ST_IDLE);
	assign result.valid        = res_valid_q;
	assign result.out_row      = res_row_q;
	assign result.out_col      = res_col_q;
	assign result.colour_index = res_colour_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			row_q        <= '0;
			col_q        <= '0;
			pr_q         <= '0;
			zr_q         <= '0;
			zi_q         <= '0;
			cr_q         <= '0;
			ci_q         <= '0;
			rr_q         <= '0;
			ii_q         <= '0;
			steps_q      <= '0;
			color_q      <= '0;
			res_valid_q  <= 1'b0;
			res_row_q    <= '0;
			res_col_q    <= '0;
			res_colour_q <= '0;
		end else begin
			if (res_valid_q && result.ready && state_q != ST_FINISH) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pix_fire) begin
						row_q   <= pixel.pixel_row;
						col_q   <= pixel.pixel_col;
						steps_q <= '0;
						color_q <= '0;
						state_q <= in_range ? ST_PT_RE : ST_FINISH;
					end
				end
				ST_PT_RE: state_q <= ST_PT_IM;
				ST_PT_IM: begin
					pr_q    <= pt_w;
					state_q <= ST_PT_END;
				end
				ST_PT_END: begin
					if (kind_q == KIND_MANDELBROT) begin
						zr_q <= '0;
						zi_q <= '0;
						cr_q <= pr_q;
						ci_q <= pt_w;
					end else begin
						zr_q <= pr_q;
						zi_q <= pt_w;
						cr_q <= julia_re_q;
						ci_q <= julia_im_q;
					end
					state_q <= ST_SQ_RR;
				end
				ST_SQ_RR: state_q <= ST_SQ_II;
				ST_SQ_II: begin
					rr_q    <= prod_s1;
					state_q <= ST_SQ_RI;
				end
				ST_SQ_RI: begin
					ii_q    <= prod_s1;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (stop_w) begin
						state_q <= ST_FINISH;
					end else begin
						zr_q    <= sat32(nr_w);
						zi_q    <= sat32(ni_w);
						steps_q <= steps_q + 1'b1;
						color_q <= (color_q == COLOR_LAST) ? '0 : color_q + 1'b1;
						state_q <= ST_SQ_RR;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						res_valid_q  <= 1'b1;
						res_row_q    <= row_q;
						res_col_q    <= col_q;
						res_colour_q <= colour_ext[COLOUR_W-1:0];
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		pix_fire |=> (state_q == ST_PT_RE || state_q == ST_FINISH))
		else $error("pixel beat did not start work");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_free) |=> (result.valid && state_q == ST_IDLE))
		else $error("finished pixel not moved to output register");

	a_only_finish_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && state_q != ST_FINISH) |=> !result.valid)
		else $error("result appeared without a finished pixel");

	a_step_loops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP && !stop_w) |=>
		(state_q == ST_SQ_RR && steps_q == $past(steps_q) + 1'b1))
		else $error("iteration did not advance");

endmodule

>>> test/tb_escape_time_fractal_pixel_unit.sv
// Self-checking bench for the escape-time fractal pixel unit: predicted colours vs result beats.
module tb_escape_time_fractal_pixel_unit;
	import efp_pkg::*;

	localparam int ONE_Q       = 1 << FRAC_BITS;
	localparam int FIX_MAX     = 32'sh7FFF_FFFF;
	localparam int FIX_MIN     = 32'sh8000_0000;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} pixel_t;

	typedef struct packed {
		logic [COORD_W-1:0]  row;
		logic [COORD_W-1:0]  col;
		logic [COLOUR_W-1:0] colour;
	} colour_beat_t;

	typedef struct {
		fractal_kind_t            kind;
		logic signed [FIX_W-1:0]  origin_re;
		logic signed [FIX_W-1:0]  origin_im;
		logic [STEP_W-1:0]        step;
		logic [LIMIT_W-1:0]       limit;
		logic signed [FIX_W-1:0]  julia_re;
		logic signed [FIX_W-1:0]  julia_im;
	} unit_regs_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  pix_valid = 1'b0;
	logic [COORD_W-1:0]    pix_row = '0;
	logic [COORD_W-1:0]    pix_col = '0;
	logic                  res_ready = 1'b0;

	unit_regs_t   unit_regs;
	pixel_t       pixels_pending[$];
	colour_beat_t colours_due[$];
	int           pixels_queued = 0;
	int           pixels_accepted = 0;
	int           failures = 0;
	int           cycle_count = 0;

	efp_cfg_if    cfg_if();
	efp_pixel_if  pix_if();
	efp_result_if res_if();

	assign cfg_if.valid     = cfg_valid;
	assign cfg_if.index     = cfg_index;
	assign cfg_if.data      = cfg_data;
	assign pix_if.valid     = pix_valid;
	assign pix_if.pixel_row = pix_row;
	assign pix_if.pixel_col = pix_col;
	assign res_if.ready     = res_ready;

	escape_time_fractal_pixel_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.pixel  (pix_if),
		.result (res_if)
	);

	always #2 clk = ~clk;

	function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic [COLOUR_W-1:0] escape_colour(input logic [COORD_W-1:0] row,
		input logic [COORD_W-1:0] col);
		logic signed [63:0] pr, pi, zr, zi, cr, ci, rr, ii, ri;
		logic [63:0] mag;
		int unsigned steps;
		steps = 0;
		if (row < MAX_DIM_DEF && col < MAX_DIM_DEF) begin
			pr = unit_regs.origin_re;
			pi = unit_regs.origin_im;
			pr = clamp32(pr + $signed(64'(col) * 64'(unit_regs.step)));
			pi = clamp32(pi + $signed(64'(row) * 64'(unit_regs.step)));
			if (unit_regs.kind == KIND_MANDELBROT) begin
				zr = 0;
				zi = 0;
				cr = pr;
				ci = pi;
			end else begin
				zr = pr;
				zi = pi;
				cr = unit_regs.julia_re;
				ci = unit_regs.julia_im;
			end
			while (steps < unit_regs.limit) begin
				rr = zr * zr;
				ii = zi * zi;
				ri = zr * zi;
				mag = $unsigned(rr) + $unsigned(ii);
				if (mag >= ESCAPE_SQ)
					break;
				zr = clamp32((rr >>> FRAC_BITS) - (ii >>> FRAC_BITS) + cr);
				zi = clamp32((ri >>> (FRAC_BITS - 1)) + ci);
				steps++;
			end
		end
		return COLOUR_W'(steps % COLORS_DEF);
	endfunction

	// keep both sides busy through the middle of the run
	function automatic bit take_gap();
		return (pixels_accepted < 400 || pixels_accepted >= 650) && $urandom_range(0, 99) < 27;
	endfunction

	always @(posedge clk) begin : feed_pixels
		pixel_t head;
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else if (!pix_valid || pix_if.ready) begin
			if (pixels_pending.size() != 0 && !take_gap()) begin
				head = pixels_pending.pop_front();
				pix_valid <= 1'b1;
				pix_row <= head.row;
				pix_col <= head.col;
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			res_ready <= 1'b0;
		else
			res_ready <= !take_gap();
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			unit_regs.kind      <= KIND_MANDELBROT;
			unit_regs.origin_re <= ORIGIN_RE_RST;
			unit_regs.origin_im <= ORIGIN_IM_RST;
			unit_regs.step      <= STEP_RST;
			unit_regs.limit     <= LIMIT_RST;
			unit_regs.julia_re  <= '0;
			unit_regs.julia_im  <= '0;
		end else if (cfg_valid && cfg_if.ready) begin
			case (cfg_index)
				REG_KIND:      unit_regs.kind      <= fractal_kind_t'(cfg_data[0]);
				REG_ORIGIN_RE: unit_regs.origin_re <= $signed(cfg_data);
				REG_ORIGIN_IM: unit_regs.origin_im <= $signed(cfg_data);
				REG_STEP:      unit_regs.step      <= cfg_data[STEP_W-1:0];
				REG_LIMIT:     unit_regs.limit     <= cfg_data[LIMIT_W-1:0];
				REG_JULIA_RE:  unit_regs.julia_re  <= $signed(cfg_data);
				REG_JULIA_IM:  unit_regs.julia_im  <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		if (pix_valid && pix_if.ready === 1'b1) begin
			colours_due.push_back({pix_row, pix_col, escape_colour(pix_row, pix_col)});
			pixels_accepted++;
		end
	end

	always @(posedge clk) begin : check_colours
		colour_beat_t want;
		if (res_if.valid === 1'b1 && res_ready) begin
			if (colours_due.size() == 0) begin
				$display("%0t: unexpected beat, actual row %0d col %0d colour %0d", $time,
					res_if.out_row, res_if.out_col, res_if.colour_index);
				failures++;
			end else begin
				want = colours_due.pop_front();
				if (res_if.out_row !== want.row || res_if.out_col !== want.col ||
						res_if.colour_index !== want.colour) begin
					$display("%0t: expected row %0d col %0d colour %0d, actual row %0d col %0d colour %0d",
						$time, want.row, want.col, want.colour,
						res_if.out_row, res_if.out_col, res_if.colour_index);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: no finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic add_pixel(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
		pixels_pending.push_back({row, col});
		pixels_queued++;
	endtask

	task automatic wait_idle();
		while (pixels_accepted != pixels_queued || colours_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input fractal_kind_t kind, input int o_re, input int o_im,
		input int unsigned step, input int unsigned limit, input int j_re, input int j_im);
		wait_idle();
		write_reg(REG_KIND, 32'(kind));
		write_reg(REG_ORIGIN_RE, o_re);
		write_reg(REG_ORIGIN_IM, o_im);
		write_reg(REG_STEP, step);
		write_reg(REG_LIMIT, limit);
		write_reg(REG_JULIA_RE, j_re);
		write_reg(REG_JULIA_IM, j_im);
	endtask

	initial begin : stimulus
		fractal_kind_t kind;
		int unsigned lim;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: four corner pixels, all of which escape
		add_pixel(0, 0);
		add_pixel(4095, 4095);
		add_pixel(0, 4095);
		add_pixel(4095, 0);
		// drop writes to the unused index
		wait_idle();
		write_reg(REG_UNUSED, '1);
		add_pixel(0, 0);

		// zero limit, zero step
		set_regs(KIND_MANDELBROT, 0, 0, 0, 0, 0, 0);
		add_pixel(7, 9);
		// c = 0 never escapes: count wraps past the colour range
		set_regs(KIND_MANDELBROT, 0, 0, 0, 300, 0, 0);
		add_pixel(4095, 4095);
		// c = -2 lands exactly on the escape radius
		set_regs(KIND_MANDELBROT, -2 * ONE_Q, 0, 0, 255, 0, 0);
		add_pixel(100, 200);
		// saturated point and widest step
		set_regs(KIND_MANDELBROT, FIX_MAX, FIX_MIN, FIX_MAX, 65535, 0, 0);
		add_pixel(0, 0);
		add_pixel(4095, 4095);
		add_pixel(4095, 0);
		// Julia constant at the extremes saturates the update
		set_regs(KIND_JULIA, ONE_Q / 2, ONE_Q / 2, 1, 65535, FIX_MIN, FIX_MAX);
		add_pixel(0, 0);
		add_pixel(4095, 4095);
		// fixed point z = 1 runs to the limit
		set_regs(KIND_JULIA, ONE_Q, 0, 0, 1000, 0, 0);
		add_pixel(4095, 0);
		set_regs(KIND_JULIA, -2 * ONE_Q, -3 * ONE_Q / 2, 3 * ONE_Q / 64, 255,
			-3 * ONE_Q / 4, ONE_Q / 10);
		add_pixel(0, 0);
		add_pixel(32, 32);
		add_pixel(63, 63);
		add_pixel(20, 40);

		for (int ph = 0; ph < 20; ph++) begin
			kind = fractal_kind_t'($urandom_range(0, 1));
			lim = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 63) : $urandom_range(64, 300);
			if ($urandom_range(0, 99) < 70)
				set_regs(kind, int'($urandom_range(0, 3 * ONE_Q)) - 5 * ONE_Q / 2,
					int'($urandom_range(0, 2 * ONE_Q)) - 3 * ONE_Q / 2,
					$urandom_range(1, 1 << 17), lim,
					int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q,
					int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
			else
				set_regs(kind, $urandom, $urandom, $urandom_range(1, FIX_MAX), lim,
					$urandom, $urandom);
			repeat (55)
				add_pixel($urandom_range(0, MAX_DIM_DEF - 1), $urandom_range(0, MAX_DIM_DEF - 1));
		end

		wait_idle();
		repeat (64) @(posedge clk);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/efp_pkg.sv
rtl/efp_if.sv
rtl/efp_mul.sv
rtl/escape_time_fractal_pixel_unit.sv
test/tb_escape_time_fractal_pixel_unit.sv
